### design/s5rq_pkg.sv
// Shared types and constants for the SOCKS5 request header parser.
`default_nettype none
package s5rq_pkg;

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_DLEN   = 3'd1;
   localparam logic [2:0] PH_ADDR   = 3'd2;
   localparam logic [2:0] PH_PHIGH  = 3'd3;
   localparam logic [2:0] PH_PLOW   = 3'd4;
   localparam logic [2:0] PH_SKIP   = 3'd5;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_SHORT_HDR  = 3'd1;
   localparam logic [2:0] ST_IPV4_SHORT = 3'd2;
   localparam logic [2:0] ST_NO_LENGTH  = 3'd3;
   localparam logic [2:0] ST_BAD_LENGTH = 3'd4;
   localparam logic [2:0] ST_DOM_SHORT  = 3'd5;
   localparam logic [2:0] ST_IPV6_SHORT = 3'd6;
   localparam logic [2:0] ST_BAD_TYPE   = 3'd7;

   localparam logic [7:0] ATYP_IPV4   = 8'h01;
   localparam logic [7:0] ATYP_DOMAIN = 8'h03;
   localparam logic [7:0] ATYP_IPV6   = 8'h04;

   localparam logic [7:0] IPV4_LEN    = 8'd4;
   localparam logic [7:0] IPV6_LEN    = 8'd16;
   localparam logic [7:0] MAX_DOM_LEN = 8'd254;

   localparam logic [7:0] HDR_VERSION  = 8'd0;
   localparam logic [7:0] HDR_COMMAND  = 8'd1;
   localparam logic [7:0] HDR_RESERVED = 8'd2;

   typedef struct packed {
      logic [2:0] phase;
      logic [7:0] byte_count;
      logic [7:0] version;
      logic [7:0] command;
      logic [7:0] reserved;
      logic [7:0] type_reg;
      logic [7:0] length;
      logic [7:0] port_high;
   } parse_state_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  addr_byte;
      logic [7:0]  addr_index;
      logic [7:0]  version;
      logic [7:0]  command;
      logic [7:0]  reserved;
      logic [7:0]  addr_type;
      logic [7:0]  domain_length;
      logic [15:0] port;
      logic [2:0]  status;
   } result_type;

endpackage
`default_nettype wire

### design/s5rq_step.sv
// Per-byte parse step: next parser state and the result for one request.
`default_nettype none
module s5rq_step import s5rq_pkg::*; (
   input  wire parse_state_type  cur,
   input  wire logic [7:0]       data_byte,
   input  wire logic             last,
   output parse_state_type       nxt,
   output logic                  emit,
   output result_type            res
);

   logic        do_sum;
   logic [2:0]  sum_status;
   logic [15:0] sum_port;
   logic [2:0]  short_status;
   logic [7:0]  addr_len;
   logic [7:0]  count_inc;

   assign count_inc = cur.byte_count + 8'd1;

   always_comb begin
      unique if (cur.type_reg == ATYP_IPV4) begin
         short_status = ST_IPV4_SHORT;
         addr_len     = IPV4_LEN;
      end else if (cur.type_reg == ATYP_DOMAIN) begin
         short_status = ST_DOM_SHORT;
         addr_len     = cur.length;
      end else begin
         short_status = ST_IPV6_SHORT;
         addr_len     = IPV6_LEN;
      end
   end

   always_comb begin
      nxt        = cur;
      emit       = 1'b0;
      res        = '0;
      do_sum     = 1'b0;
      sum_status = ST_OK;
      sum_port   = '0;
      unique case (cur.phase)
         PH_HEADER: begin
            unique if (cur.byte_count == HDR_VERSION) begin
               nxt.version   = data_byte;
               nxt.command   = '0;
               nxt.reserved  = '0;
               nxt.type_reg  = '0;
               nxt.length    = '0;
               nxt.port_high = '0;
            end else if (cur.byte_count == HDR_COMMAND) begin
               nxt.command = data_byte;
            end else if (cur.byte_count == HDR_RESERVED) begin
               nxt.reserved = data_byte;
            end else begin
               nxt.type_reg = data_byte;
            end
            if (cur.byte_count <= HDR_RESERVED) begin
               if (last) begin
                  do_sum     = 1'b1;
                  sum_status = ST_SHORT_HDR;
               end else begin
                  nxt.byte_count = count_inc;
               end
            end else begin
               nxt.byte_count = '0;
               if (data_byte != ATYP_IPV4 && data_byte != ATYP_DOMAIN &&
                   data_byte != ATYP_IPV6) begin
                  do_sum     = 1'b1;
                  sum_status = ST_BAD_TYPE;
               end else if (last) begin
                  do_sum = 1'b1;
                  unique if (data_byte == ATYP_DOMAIN) sum_status = ST_NO_LENGTH;
                  else if (data_byte == ATYP_IPV4)    sum_status = ST_IPV4_SHORT;
                  else                                sum_status = ST_IPV6_SHORT;
               end else begin
                  nxt.phase = (data_byte == ATYP_DOMAIN) ? PH_DLEN : PH_ADDR;
               end
            end
         end
         PH_DLEN: begin
            if (data_byte == 8'd0 || data_byte > MAX_DOM_LEN) begin
               do_sum     = 1'b1;
               sum_status = ST_BAD_LENGTH;
            end else begin
               nxt.length = data_byte;
               if (last) begin
                  do_sum     = 1'b1;
                  sum_status = ST_DOM_SHORT;
               end else begin
                  nxt.byte_count = '0;
                  nxt.phase      = PH_ADDR;
               end
            end
         end
         PH_ADDR: begin
            if (last) begin
               do_sum     = 1'b1;
               sum_status = short_status;
            end else begin
               emit           = 1'b1;
               res.addr_byte  = data_byte;
               res.addr_index = cur.byte_count;
               if (count_inc >= addr_len) begin
                  nxt.byte_count = '0;
                  nxt.phase      = PH_PHIGH;
               end else begin
                  nxt.byte_count = count_inc;
               end
            end
         end
         PH_PHIGH: begin
            if (last) begin
               do_sum     = 1'b1;
               sum_status = short_status;
            end else begin
               nxt.port_high = data_byte;
               nxt.phase     = PH_PLOW;
            end
         end
         PH_PLOW: begin
            do_sum     = 1'b1;
            sum_status = ST_OK;
            sum_port   = {cur.port_high, data_byte};
         end
         default: begin
            if (last) begin
               nxt.phase      = PH_HEADER;
               nxt.byte_count = '0;
            end
         end
      endcase
      if (do_sum) begin
         emit              = 1'b1;
         res               = '0;
         res.kind          = 1'b1;
         res.version       = nxt.version;
         res.command       = nxt.command;
         res.reserved      = nxt.reserved;
         res.addr_type     = nxt.type_reg;
         res.domain_length = (nxt.type_reg == ATYP_DOMAIN) ? nxt.length : 8'd0;
         res.port          = sum_port;
         res.status        = sum_status;
         nxt.phase         = last ? PH_HEADER : PH_SKIP;
         nxt.byte_count    = '0;
      end
   end

endmodule
`default_nettype wire

### design/s5rq_out_reg.sv
// Result register with valid/stall handshake toward the receiver.
`default_nettype none
module s5rq_out_reg import s5rq_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  wire result_type  res,
   input  wire logic        out_stall,
   output logic             ready,
   output logic             out_valid,
   output result_type       out_res
);

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   assign ready     = !valid_ff || !out_stall;
   assign valid_in  = ready ? load : valid_ff;
   assign out_valid = valid_ff;
   assign out_res   = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && load) begin
         res_ff <= res;
      end
   end

endmodule
`default_nettype wire

### design/socks5_request_header_parser_core.sv
// Top level of the SOCKS5 request header parser.
//
// Usage: raw request bytes enter on the req_ channel (req_data_byte, with
// req_last on the final byte of each buffer). Results leave on the rsp_
// channel: address byte records (rsp_kind 0) with their index, and one
// summary record (rsp_kind 1) per buffer with header bytes, port and status.
// A request is accepted when req_valid is high and req_stall is low.
// A result appears on rsp_ in the cycle after the request that causes
// it. One request per cycle while req_stall is low; parser state is updated
// by a single combinational step and the result lands in one output register.
// Header, length and high port-byte requests produce no result unless they
// end the buffer or fail a check; trailing bytes after a summary never do.
// The receiver may hold rsp_stall; the output register then holds its
// result and req_stall rises only while that register is full and stalled,
// so an accepted request never loses its result.
// Reset (synchronous, active high) empties the output register and returns
// the parser to the header phase with all captured fields at zero.
`default_nettype none
module socks5_request_header_parser_core import s5rq_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [7:0]       rsp_addr_byte,
   output logic [7:0]       rsp_addr_index,
   output logic [7:0]       rsp_version,
   output logic [7:0]       rsp_command,
   output logic [7:0]       rsp_reserved,
   output logic [7:0]       rsp_addr_type,
   output logic [7:0]       rsp_domain_length,
   output logic [15:0]      rsp_port,
   output logic [2:0]       rsp_status
);

   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type step_nxt;
   result_type      step_res;
   result_type      out_res;
   logic            step_emit;
   logic            ready;
   logic            accept;

   assign req_stall = !ready;
   assign accept    = req_valid && ready;
   assign state_in  = accept ? step_nxt : state_ff;

   // all-zero state is the header phase awaiting the first byte
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   s5rq_step u_step (
      .cur       (state_ff),
      .data_byte (req_data_byte),
      .last      (req_last),
      .nxt       (step_nxt),
      .emit      (step_emit),
      .res       (step_res)
   );

   s5rq_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && step_emit),
      .res       (step_res),
      .out_stall (rsp_stall),
      .ready     (ready),
      .out_valid (rsp_valid),
      .out_res   (out_res)
   );

   assign rsp_kind          = out_res.kind;
   assign rsp_addr_byte     = out_res.addr_byte;
   assign rsp_addr_index    = out_res.addr_index;
   assign rsp_version       = out_res.version;
   assign rsp_command       = out_res.command;
   assign rsp_reserved      = out_res.reserved;
   assign rsp_addr_type     = out_res.addr_type;
   assign rsp_domain_length = out_res.domain_length;
   assign rsp_port          = out_res.port;
   assign rsp_status        = out_res.status;

endmodule
`default_nettype wire

### design/s5rq_checker.sv
// Port-level checks for the SOCKS5 request header parser, bound to the top.
`default_nettype none
module s5rq_checker import s5rq_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_kind,
   input wire logic [7:0]  rsp_addr_byte,
   input wire logic [7:0]  rsp_addr_index,
   input wire logic [7:0]  rsp_version,
   input wire logic [2:0]  rsp_status,
   input wire logic [15:0] rsp_port
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) &&
         $stable(rsp_addr_byte) && $stable(rsp_status) && $stable(rsp_port))
      else $error("stalled result changed");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled while output free");

   a_addr_rec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> rsp_version == 8'd0 && rsp_status == ST_OK &&
         rsp_port == 16'd0 && rsp_addr_index <= 8'd253)
      else $error("bad address record");

   a_sum_rec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_addr_byte == 8'd0 && rsp_addr_index == 8'd0 &&
         (rsp_status == ST_OK || rsp_port == 16'd0))
      else $error("bad summary record");

endmodule

bind socks5_request_header_parser_core s5rq_checker u_s5rq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_kind       (rsp_kind),
   .rsp_addr_byte  (rsp_addr_byte),
   .rsp_addr_index (rsp_addr_index),
   .rsp_version    (rsp_version),
   .rsp_status     (rsp_status),
   .rsp_port       (rsp_port)
);
`default_nettype wire
